// ----- rtl/core/poi_pkg.sv -----
// Shared constants, command word and CORDIC angle table for the planar odometry integrator.
// No dependencies; used by poi_ctrl, poi_datapath and planar_odometry_integrator_top.
package poi_pkg;

   // Configuration of the integrator.
   localparam int CORDIC_STEPS  = 16;
   localparam int POSITION_BITS = 48;

   // CORDIC: the angle table holds 24 entries, so the rotation is capped at that many steps.
   localparam int ATAN_ENTRIES  = 24;
   localparam int ATAN_IDX_W    = $clog2(ATAN_ENTRIES);
   localparam int CORDIC_ITERS  = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam int CORDIC_W      = 34;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   // Velocity times sin/cos products.
   localparam int VEL_W         = 16;
   localparam int PROD_FULL_W   = VEL_W + CORDIC_W;
   localparam int PROD_W        = 48;
   localparam int MX_W          = 64;

   // Heading increment: yaw_rate * dt * HEADING_SCALE / 2^32, rounded half up.
   localparam int HW_W          = 33;
   localparam logic signed [31:0] HEADING_SCALE = 32'sd716770142;
   localparam logic signed [MX_W-1:0] HEADING_ROUND = 64'sd2147483648;

   // Position increment: divide by 1024000000 = 2^16 * 15625, rounded half away from zero.
   // The division by 15625 multiplies by ceil(2^62 / 15625) and keeps the bits from 2^62 up;
   // exact for any 48-bit dividend. Four partial products, one per cycle.
   localparam logic [MX_W-1:0] POS_ROUND = 64'd512000000;
   localparam int DIV_SHIFT      = 16;
   localparam int DVD_W          = MX_W - DIV_SHIFT;
   localparam int DVD_HALF_W     = DVD_W / 2;
   localparam int RECIP_W        = 49;
   localparam int RECIP_LO_W     = 32;
   localparam logic [RECIP_W-1:0] RECIP_15625 = 49'd295147905179353;
   localparam int RECIP_SHIFT    = 62;
   localparam int RPROD_W        = DVD_W + RECIP_W;
   localparam int QUO_W          = RPROD_W - RECIP_SHIFT;
   localparam int DIV_CYCLES     = 4;

   // Signed step added to a position accumulator, and the saturating sum width.
   localparam int STEP_W    = QUO_W + 1;
   localparam int SUM_W     = ((POSITION_BITS > STEP_W) ? POSITION_BITS : STEP_W) + 1;
   localparam int OUT_SRC_W = POSITION_BITS - 16;
   localparam int OUT_EXT_W = (OUT_SRC_W > 32) ? OUT_SRC_W : 32;

   // Shared counter for CORDIC iterations and divider cycles.
   localparam int CNT_MAX = (CORDIC_ITERS > DIV_CYCLES) ? CORDIC_ITERS : DIV_CYCLES;
   localparam int CNT_W   = $clog2(CNT_MAX);

   // Command word from the controller to the datapath.
   typedef struct packed {
      logic             start;
      logic             rotate;
      logic             multiply;
      logic             combine;
      logic             scale;
      logic             round;
      logic             divide;
      logic             commit;
      logic [CNT_W-1:0] step;
   } poi_cmd_type;

   // atan(2^-i) in units of 2^-32 turn.
   function automatic logic [29:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
      logic [29:0] val;
      case (idx)
         5'd0:    val = 30'd536870912;
         5'd1:    val = 30'd316933406;
         5'd2:    val = 30'd167458907;
         5'd3:    val = 30'd85004756;
         5'd4:    val = 30'd42667331;
         5'd5:    val = 30'd21354465;
         5'd6:    val = 30'd10679838;
         5'd7:    val = 30'd5340245;
         5'd8:    val = 30'd2670163;
         5'd9:    val = 30'd1335087;
         5'd10:   val = 30'd667544;
         5'd11:   val = 30'd333772;
         5'd12:   val = 30'd166886;
         5'd13:   val = 30'd83443;
         5'd14:   val = 30'd41722;
         5'd15:   val = 30'd20861;
         5'd16:   val = 30'd10430;
         5'd17:   val = 30'd5215;
         5'd18:   val = 30'd2608;
         5'd19:   val = 30'd1304;
         5'd20:   val = 30'd652;
         5'd21:   val = 30'd326;
         5'd22:   val = 30'd163;
         5'd23:   val = 30'd81;
         default: val = 30'd0;
      endcase
      return val;
   endfunction

endpackage

// ----- rtl/core/poi_ctrl.sv -----
// Sequencer for the planar odometry integrator: steps the datapath through
// CORDIC, multiply, round, divide and commit. Depends on poi_pkg.
module poi_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output poi_pkg::poi_cmd_type cmd
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_ROTATE   = 8'b0000_0010,
      ST_MULTIPLY = 8'b0000_0100,
      ST_COMBINE  = 8'b0000_1000,
      ST_SCALE    = 8'b0001_0000,
      ST_ROUND    = 8'b0010_0000,
      ST_DIVIDE   = 8'b0100_0000,
      ST_COMMIT   = 8'b1000_0000
   } ctrl_state_type;

   localparam logic [poi_pkg::CNT_W-1:0] ROT_LAST =
      poi_pkg::CNT_W'(poi_pkg::CORDIC_ITERS - 1);
   localparam logic [poi_pkg::CNT_W-1:0] DIV_LAST =
      poi_pkg::CNT_W'(poi_pkg::DIV_CYCLES - 1);

   ctrl_state_type              state_ff, state_in;
   logic [poi_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      cmd          = '0;
      cmd.step     = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               cnt_in    = '0;
               state_in  = ST_ROTATE;
            end
         end
         ST_ROTATE: begin
            cmd.rotate = 1'b1;
            if (cnt_ff == ROT_LAST) begin
               cnt_in   = '0;
               state_in = ST_MULTIPLY;
            end else begin
               cnt_in = poi_pkg::CNT_W'(cnt_ff + 1'b1);
            end
         end
         ST_MULTIPLY: begin
            cmd.multiply = 1'b1;
            state_in     = ST_COMBINE;
         end
         ST_COMBINE: begin
            cmd.combine = 1'b1;
            state_in    = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            cnt_in    = '0;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.divide = 1'b1;
            if (cnt_ff == DIV_LAST) begin
               cnt_in   = '0;
               state_in = ST_COMMIT;
            end else begin
               cnt_in = poi_pkg::CNT_W'(cnt_ff + 1'b1);
            end
         end
         ST_COMMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/core/poi_datapath.sv -----
// Datapath of the planar odometry integrator: CORDIC rotator, products, reciprocal
// multiplier for the constant division, saturating x and y accumulators, wrapping heading
// accumulator and output register. Depends on poi_pkg.
module poi_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  poi_pkg::poi_cmd_type        cmd,
   input  logic signed [15:0]          req_vel_forward,
   input  logic signed [15:0]          req_vel_lateral,
   input  logic signed [15:0]          req_yaw_rate,
   input  logic        [15:0]          req_elapsed_us,
   output logic signed [31:0]          rsp_pose_x,
   output logic signed [31:0]          rsp_pose_y,
   output logic        [15:0]          rsp_heading
);

   localparam int CW  = poi_pkg::CORDIC_W;
   localparam int PB  = poi_pkg::POSITION_BITS;
   localparam int DW  = poi_pkg::DVD_W;
   localparam int HH  = poi_pkg::DVD_HALF_W;
   localparam int ML  = poi_pkg::RECIP_LO_W;
   localparam int PW  = poi_pkg::RPROD_W;
   localparam int SW  = poi_pkg::SUM_W;
   localparam int OW  = poi_pkg::OUT_EXT_W;
   localparam int STW = poi_pkg::STEP_W;

   localparam logic signed [CW-1:0] QUARTER = CW'(64'sh4000_0000);
   localparam logic signed [CW-1:0] HALF    = CW'(64'sh8000_0000);

   // one partial product of dividend times reciprocal, placed at its weight
   function automatic logic [PW-1:0] recip_part(input logic [DW-1:0] dvd,
                                                input logic [1:0]    sel);
      logic [HH-1:0]    half;
      logic [ML-1:0]    mul;
      logic [HH+ML-1:0] pp;
      logic [PW-1:0]    part;
      half = sel[1] ? dvd[DW-1 -: HH] : dvd[HH-1:0];
      mul  = sel[0] ? ML'(poi_pkg::RECIP_15625[poi_pkg::RECIP_W-1:ML])
                    : poi_pkg::RECIP_15625[ML-1:0];
      pp   = half * mul;
      part = PW'(pp);
      if (sel[0]) part = part << ML;
      if (sel[1]) part = part << HH;
      return part;
   endfunction

   // add a step to an accumulator, clamping at the accumulator limits
   function automatic logic signed [PB-1:0] sat_add(input logic signed [PB-1:0]  acc,
                                                    input logic signed [STW-1:0] stp);
      logic signed [SW-1:0] sum;
      logic                 fits;
      sum  = SW'(acc) + SW'(stp);
      fits = (&sum[SW-1:PB-1]) | ~(|sum[SW-1:PB-1]);
      if (fits) begin
         return sum[PB-1:0];
      end else if (sum[SW-1]) begin
         return {1'b1, {(PB-1){1'b0}}};
      end else begin
         return {1'b0, {(PB-1){1'b1}}};
      end
   endfunction

   // accumulator >>> 16, clamped to 32 bits
   function automatic logic [31:0] out32(input logic signed [PB-1:0] acc);
      logic signed [OW-1:0] ext;
      logic                 fits;
      ext  = OW'(signed'(acc[PB-1:16]));
      fits = (&ext[OW-1:31]) | ~(|ext[OW-1:31]);
      if (fits) begin
         return ext[31:0];
      end else if (ext[OW-1]) begin
         return 32'h8000_0000;
      end else begin
         return 32'h7FFF_FFFF;
      end
   endfunction

   // input word
   logic signed [15:0]                 vf_ff, vl_ff;
   logic        [15:0]                 dt_ff;
   logic signed [poi_pkg::HW_W-1:0]    hw_ff;
   // CORDIC
   logic signed [CW-1:0]               cx_ff, cy_ff, cz_ff;
   logic signed [CW-1:0]               cx_in, cy_in, cz_in;
   logic signed [CW-1:0]               z0;
   logic                               flip_ff, flip_in;
   // products
   logic signed [poi_pkg::PROD_FULL_W-1:0] pfc_ff, pls_ff, pfs_ff, plc_ff;
   logic signed [poi_pkg::PROD_FULL_W-1:0] dx_full, dy_full;
   logic signed [poi_pkg::PROD_W-1:0]  sx_ff, sy_ff;
   logic signed [poi_pkg::MX_W-1:0]    mx_ff, my_ff, hh_ff;
   logic signed [16:0]                 dt_s;
   // rounding and division
   logic        [poi_pkg::MX_W-1:0]    ax, ay;
   logic                               negx_ff, negy_ff;
   logic        [31:0]                 dh_ff, dh_in;
   logic        [DW-1:0]               dvdx_ff, dvdy_ff;
   logic        [PW-1:0]               accx_ff, accy_ff;
   logic        [PW-1:0]               partx, party;
   logic        [poi_pkg::QUO_W-1:0]   qx, qy;
   // pose
   logic signed [PB-1:0]               xacc_ff, yacc_ff, xacc_in, yacc_in;
   logic        [31:0]                 head_ff, head_in;
   logic signed [STW-1:0]              stepx, stepy;
   logic signed [31:0]                 posx_ff, posy_ff;
   logic        [15:0]                 rhead_ff;

   // heading reduced to a quarter turn either side; fold the rest by a half turn
   always_comb begin
      z0      = CW'(signed'(head_ff));
      flip_in = 1'b0;
      if (z0 > QUARTER) begin
         z0      = z0 - HALF;
         flip_in = 1'b1;
      end else if (z0 < -QUARTER) begin
         z0      = z0 + HALF;
         flip_in = 1'b1;
      end
   end

   // one CORDIC iteration
   always_comb begin
      if (!cz_ff[CW-1]) begin
         cx_in = cx_ff - (cy_ff >>> cmd.step);
         cy_in = cy_ff + (cx_ff >>> cmd.step);
         cz_in = cz_ff - CW'(poi_pkg::atan_turn(poi_pkg::ATAN_IDX_W'(cmd.step)));
      end else begin
         cx_in = cx_ff + (cy_ff >>> cmd.step);
         cy_in = cy_ff - (cx_ff >>> cmd.step);
         cz_in = cz_ff + CW'(poi_pkg::atan_turn(poi_pkg::ATAN_IDX_W'(cmd.step)));
      end
   end

   // negating both sin and cos negates the whole combination
   assign dx_full = flip_ff ? (pls_ff - pfc_ff) : (pfc_ff - pls_ff);
   assign dy_full = flip_ff ? -(pfs_ff + plc_ff) : (pfs_ff + plc_ff);
   assign dt_s    = signed'({1'b0, dt_ff});

   assign ax    = (mx_ff[poi_pkg::MX_W-1] ? poi_pkg::MX_W'(-mx_ff) : mx_ff) + poi_pkg::POS_ROUND;
   assign ay    = (my_ff[poi_pkg::MX_W-1] ? poi_pkg::MX_W'(-my_ff) : my_ff) + poi_pkg::POS_ROUND;
   assign dh_in = 32'((hh_ff + poi_pkg::HEADING_ROUND) >>> 32);

   assign partx = recip_part(dvdx_ff, cmd.step[1:0]);
   assign party = recip_part(dvdy_ff, cmd.step[1:0]);
   assign qx    = accx_ff[PW-1:poi_pkg::RECIP_SHIFT];
   assign qy    = accy_ff[PW-1:poi_pkg::RECIP_SHIFT];

   always_comb begin
      stepx   = signed'({1'b0, qx});
      stepy   = signed'({1'b0, qy});
      if (negx_ff) stepx = -stepx;
      if (negy_ff) stepy = -stepy;
      xacc_in = sat_add(xacc_ff, stepx);
      yacc_in = sat_add(yacc_ff, stepy);
      head_in = head_ff + dh_ff;
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         vf_ff   <= req_vel_forward;
         vl_ff   <= req_vel_lateral;
         dt_ff   <= req_elapsed_us;
         hw_ff   <= poi_pkg::HW_W'(req_yaw_rate) *
                    poi_pkg::HW_W'(signed'({1'b0, req_elapsed_us}));
         cx_ff   <= poi_pkg::CORDIC_GAIN_Q30;
         cy_ff   <= '0;
         cz_ff   <= z0;
         flip_ff <= flip_in;
      end
      if (cmd.rotate) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         cz_ff <= cz_in;
      end
      if (cmd.multiply) begin
         pfc_ff <= vf_ff * cx_ff;
         pls_ff <= vl_ff * cy_ff;
         pfs_ff <= vf_ff * cy_ff;
         plc_ff <= vl_ff * cx_ff;
      end
      if (cmd.combine) begin
         sx_ff <= dx_full[poi_pkg::PROD_W-1:0];
         sy_ff <= dy_full[poi_pkg::PROD_W-1:0];
      end
      if (cmd.scale) begin
         mx_ff <= sx_ff * dt_s;
         my_ff <= sy_ff * dt_s;
         hh_ff <= hw_ff * poi_pkg::HEADING_SCALE;
      end
      if (cmd.round) begin
         negx_ff <= mx_ff[poi_pkg::MX_W-1];
         negy_ff <= my_ff[poi_pkg::MX_W-1];
         dvdx_ff <= ax[poi_pkg::MX_W-1:poi_pkg::DIV_SHIFT];
         dvdy_ff <= ay[poi_pkg::MX_W-1:poi_pkg::DIV_SHIFT];
         accx_ff <= '0;
         accy_ff <= '0;
         dh_ff   <= dh_in;
      end
      if (cmd.divide) begin
         accx_ff <= accx_ff + partx;
         accy_ff <= accy_ff + party;
      end
      if (cmd.commit) begin
         posx_ff  <= out32(xacc_in);
         posy_ff  <= out32(yacc_in);
         rhead_ff <= head_in[31:16];
      end
   end

   // pose state
   always_ff @(posedge clock) begin
      if (reset) begin
         xacc_ff <= '0;
         yacc_ff <= '0;
         head_ff <= '0;
      end else if (cmd.commit) begin
         xacc_ff <= xacc_in;
         yacc_ff <= yacc_in;
         head_ff <= head_in;
      end
   end

   assign rsp_pose_x  = posx_ff;
   assign rsp_pose_y  = posy_ff;
   assign rsp_heading = rhead_ff;

endmodule

// ----- rtl/core/planar_odometry_integrator_top.sv -----
// Top level of the planar odometry integrator (2D dead reckoning).
// Instantiates poi_ctrl and poi_datapath; depends on poi_pkg.
//
//  channel  direction  handshake            word
//  req_     in         req_valid/req_stall  vel_forward, vel_lateral, yaw_rate, elapsed_us
//  rsp_     out        rsp_valid/rsp_stall  pose_x, pose_y, heading
//
// Each word runs from the accepting cycle through the commit that loads the result
// register: accept and load, CORDIC_ITERS (16) rotation steps of the shared shift-add
// unit, the multiply, combine, scale and round steps, DIV_CYCLES (4) reciprocal multiply
// steps for the division by 1024000000, then commit; rsp_valid rises the cycle after.
// The sequencer handles one word at a time; req_stall is high from the cycle after
// acceptance through commit, so a new word is taken only once the last one has committed.
// A finished result sits in the output register; the next word is accepted while
// it waits, and commit holds only if the previous result is still stalled.
// Reset (synchronous) clears the pose to zero and empties the output register.
module planar_odometry_integrator_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_vel_forward,
   input  logic signed [15:0] req_vel_lateral,
   input  logic signed [15:0] req_yaw_rate,
   input  logic        [15:0] req_elapsed_us,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_pose_x,
   output logic signed [31:0] rsp_pose_y,
   output logic        [15:0] rsp_heading
);

   poi_pkg::poi_cmd_type cmd;

   // sequence the work of one word
   poi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // rotate, multiply, divide, accumulate
   poi_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_vel_forward (req_vel_forward),
      .req_vel_lateral (req_vel_lateral),
      .req_yaw_rate    (req_yaw_rate),
      .req_elapsed_us  (req_elapsed_us),
      .rsp_pose_x      (rsp_pose_x),
      .rsp_pose_y      (rsp_pose_y),
      .rsp_heading     (rsp_heading)
   );

endmodule
